// ===== hw/rtl/uifhr_pkg.sv =====
// Package for the idle-framed hex frame receiver: command and status codes,
// frame marker constants and the hex character helpers.
// No dependencies.
`timescale 1ns / 1ps

package uifhr_pkg;

  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_GOOD  = 2'd0,
    ST_SHORT = 2'd1,
    ST_ODD   = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic [7:0] CH_OPEN        = 8'h3C;
  localparam logic [7:0] CH_CLOSE       = 8'h3E;
  localparam int         MIN_CHARS      = 12;
  localparam logic [7:0] IDLE_LIMIT_RST = 8'd2;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // '0'..'9' map to c[3:0]; above '9' the value is c - 'A' + 10, i.e. c[3:0] + 9
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    nibble_of = (c <= 8'h39) ? c[3:0] : (c[3:0] + 4'd9);
  endfunction

endpackage

// ===== hw/rtl/uifhr_in_if.sv =====
// Input channel of the hex frame receiver: valid/ready plus the item fields.
// No dependencies.
`timescale 1ns / 1ps

interface uifhr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source (output valid, command, rx_byte, read_index, input ready);
  modport sink (input valid, command, rx_byte, read_index, output ready);
endinterface

// ===== hw/rtl/uifhr_out_if.sv =====
// Result channel of the hex frame receiver: valid/ready plus the result fields.
// No dependencies.
`timescale 1ns / 1ps

interface uifhr_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [1:0] frame_status;
  logic [7:0] payload_length;
  logic [7:0] data_byte;

  modport source (output valid, result_kind, frame_status, payload_length, data_byte,
                  input ready);
  modport sink (input valid, result_kind, frame_status, payload_length, data_byte,
                output ready);
endinterface

// ===== hw/rtl/uifhr_cfg_if.sv =====
// Configuration write channel of the hex frame receiver (idle tick limit).
// No dependencies.
`timescale 1ns / 1ps

interface uifhr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/uart_idle_framed_hex_frame_receiver.sv =====
// Top level of the idle-framed ASCII hex frame receiver.
// Depends on uifhr_pkg and the uifhr_in_if, uifhr_out_if, uifhr_cfg_if interfaces.
//
//   channel  | dir | fields
//   ---------+-----+-------------------------------------------------
//   in_ch    | in  | command[1:0], rx_byte[7:0], read_index[7:0]
//   out_ch   | out | result_kind, frame_status[1:0], payload_length[7:0], data_byte[7:0]
//   cfg_ch   | in  | data[7:0] = idle tick limit, always ready
//
// One beat is accepted per cycle while in_ch.ready is high. Frame state updates at the
// accept edge; a result passes the store read register and then the output register.
// The store is a single-port-write, single-read memory with registered read data.
// A stall on out_ch holds both stages and drops in_ch.ready once the read stage is full.
// Synchronous active-low reset clears control state only; the store needs no clearing.
`timescale 1ns / 1ps

module uart_idle_framed_hex_frame_receiver #(
  parameter int FRAME_CHARS = 320
) (
  input  logic        clk,
  input  logic        rst_n,
  uifhr_in_if.sink    in_ch,
  uifhr_out_if.source out_ch,
  uifhr_cfg_if.sink   cfg_ch
);
  import uifhr_pkg::*;

  localparam int STORE_DEPTH = FRAME_CHARS / 2;
  localparam int CW          = $clog2(FRAME_CHARS + 1);
  localparam int AW          = $clog2(STORE_DEPTH);

  logic [7:0]    mem [STORE_DEPTH];

  logic [7:0]    limit_r;
  logic [CW-1:0] char_count_r, char_count_nxt;
  logic          loading_r, loading_nxt;
  logic          held_r, held_nxt;
  logic [7:0]    idle_r, idle_nxt;
  logic          start_ok_r, start_ok_nxt;
  logic          bad_r, bad_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic [3:0]    hi_r, hi_nxt;

  logic          s1_valid_r;
  logic          s1_kind_r;
  logic [1:0]    s1_status_r;
  logic [7:0]    s1_plen_r;
  logic          s1_inrange_r;
  logic [7:0]    rd_data_r;

  logic          out_valid_r;
  logic          out_kind_r;
  logic [1:0]    out_status_r;
  logic [7:0]    out_plen_r;
  logic [7:0]    out_data_r;

  logic          accept;
  logic          s1_adv;
  cmd_t          cmd;
  logic          res_valid;
  logic          res_kind;
  status_t       res_status;
  logic [7:0]    res_plen;
  logic          rd_inrange;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [CW-1:0] pos;

  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cmd         = cmd_t'(in_ch.command);
  assign cfg_ch.ready = 1'b1;

  assign rd_inrange = (int'(in_ch.read_index) < STORE_DEPTH);
  assign rd_addr    = AW'(in_ch.read_index);
  assign pos        = char_count_r - CW'(1);

  always_comb begin
    char_count_nxt = char_count_r;
    loading_nxt    = loading_r;
    held_nxt       = held_r;
    idle_nxt       = idle_r;
    start_ok_nxt   = start_ok_r;
    bad_nxt        = bad_r;
    prev_nxt       = prev_r;
    hi_nxt         = hi_r;
    res_valid      = 1'b0;
    res_kind       = KIND_REPORT;
    res_status     = ST_GOOD;
    res_plen       = 8'd0;
    wr_en          = 1'b0;
    wr_addr        = AW'(pos[CW-1:1] - (CW-1)'(1));
    wr_data        = {hi_r, nibble_of(prev_r)};
    unique case (cmd)
      CMD_BYTE: begin
        if (!held_r) begin
          if (!loading_r) begin
            loading_nxt    = 1'b1;
            char_count_nxt = CW'(1);
            idle_nxt       = 8'd0;
            start_ok_nxt   = (in_ch.rx_byte == CH_OPEN);
            bad_nxt        = 1'b0;
            hi_nxt         = 4'd0;
            prev_nxt       = in_ch.rx_byte;
          end else if (char_count_r < CW'(FRAME_CHARS)) begin
            if (char_count_r >= CW'(2)) begin
              if (!is_hex(prev_r)) begin
                bad_nxt = 1'b1;
              end
              if (pos[0]) begin
                hi_nxt = nibble_of(prev_r);
              end else begin
                wr_en = 1'b1;
              end
            end
            prev_nxt       = in_ch.rx_byte;
            char_count_nxt = char_count_r + CW'(1);
            idle_nxt       = 8'd0;
          end
        end
      end
      CMD_TICK: begin
        if (loading_r && !held_r) begin
          if (idle_r < limit_r) begin
            idle_nxt = idle_r + 8'd1;
          end else begin
            loading_nxt = 1'b0;
            held_nxt    = 1'b1;
            res_valid   = 1'b1;
            priority if (char_count_r < CW'(MIN_CHARS)) begin
              res_status = ST_SHORT;
            end else if (char_count_r[0]) begin
              res_status = ST_ODD;
            end else if (!start_ok_r || bad_r || (prev_r != CH_CLOSE)) begin
              res_status = ST_BAD;
            end else begin
              res_status = ST_GOOD;
              res_plen   = 8'((char_count_r >> 1) - CW'(1));
            end
          end
        end
      end
      CMD_RELEASE: begin
        held_nxt       = 1'b0;
        loading_nxt    = 1'b0;
        char_count_nxt = '0;
        idle_nxt       = 8'd0;
        start_ok_nxt   = 1'b0;
        bad_nxt        = 1'b0;
        prev_nxt       = 8'd0;
        hi_nxt         = 4'd0;
      end
      CMD_READ: begin
        res_valid = 1'b1;
        res_kind  = KIND_READ;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (accept && (cmd == CMD_READ) && rd_inrange) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r      <= IDLE_LIMIT_RST;
      char_count_r <= '0;
      loading_r    <= 1'b0;
      held_r       <= 1'b0;
      idle_r       <= 8'd0;
      start_ok_r   <= 1'b0;
      bad_r        <= 1'b0;
      prev_r       <= 8'd0;
      hi_r         <= 4'd0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        limit_r <= cfg_ch.data;
      end
      if (accept) begin
        char_count_r <= char_count_nxt;
        loading_r    <= loading_nxt;
        held_r       <= held_nxt;
        idle_r       <= idle_nxt;
        start_ok_r   <= start_ok_nxt;
        bad_r        <= bad_nxt;
        prev_r       <= prev_nxt;
        hi_r         <= hi_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= res_valid;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      s1_kind_r    <= res_kind;
      s1_status_r  <= res_status;
      s1_plen_r    <= res_plen;
      s1_inrange_r <= (cmd == CMD_READ) && rd_inrange;
    end
    if (s1_adv && s1_valid_r) begin
      out_kind_r   <= s1_kind_r;
      out_status_r <= s1_status_r;
      out_plen_r   <= s1_plen_r;
      out_data_r   <= s1_inrange_r ? rd_data_r : 8'd0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_kind    = out_kind_r;
  assign out_ch.frame_status   = out_status_r;
  assign out_ch.payload_length = out_plen_r;
  assign out_ch.data_byte      = out_data_r;

endmodule

// ===== dv/tb_uart_idle_framed_hex_frame_receiver.sv =====
// Self-checking testbench for the idle-framed ASCII hex frame receiver.
// Drives frames, ticks, releases and reads, predicts reports and read data in
// a shadow model. Depends on uifhr_pkg, the three channel interfaces and the RTL top.
`timescale 1ns / 1ps

module tb_uart_idle_framed_hex_frame_receiver;
  import uifhr_pkg::*;

  localparam int FRAME_CHARS  = 320;
  localparam int STORE_DEPTH  = FRAME_CHARS / 2;
  localparam int QUIET_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BEATS = 500;
  localparam logic [7:0] CHR_ZERO = "0";
  localparam logic [7:0] CHR_NINE = "9";
  localparam logic [7:0] CHR_A    = "A";
  localparam logic [7:0] CHR_F    = "F";

  typedef struct packed {
    logic       kind;
    status_t    status;
    logic [7:0] plen;
    logic [7:0] data;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n;

  uifhr_in_if  in_ch ();
  uifhr_out_if out_ch ();
  uifhr_cfg_if cfg_ch ();

  uart_idle_framed_hex_frame_receiver #(.FRAME_CHARS(FRAME_CHARS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // shadow state of the receiver
  logic [7:0] sh_limit = IDLE_LIMIT_RST;
  logic [8:0] sh_count = '0;
  logic       sh_loading = 1'b0;
  logic       sh_held = 1'b0;
  logic [7:0] sh_idle = '0;
  logic       sh_start_ok = 1'b0;
  logic       sh_bad = 1'b0;
  logic [7:0] sh_prev = '0;
  logic [3:0] sh_high = '0;
  logic [7:0] shadow_store [STORE_DEPTH];
  bit         store_written [STORE_DEPTH];

  frame_result_t awaited_results[$];
  int  mismatches = 0;
  int  beats_sent = 0;
  int  cycle_count = 0;
  int  hold_request = 0;
  int  hold_left = 0;
  bit  idle_en = 1'b1;
  bit  stall_en = 1'b1;

  function automatic logic is_hex_char(logic [7:0] c);
    return ((c >= CHR_ZERO) && (c <= CHR_NINE)) || ((c >= CHR_A) && (c <= CHR_F));
  endfunction

  function automatic logic [3:0] char_nibble(logic [7:0] c);
    logic [7:0] v;
    v = (c <= CHR_NINE) ? (c - CHR_ZERO) : (c - CHR_A + 8'd10);
    return v[3:0];
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] v);
    return (v < 4'd10) ? (CHR_ZERO + v) : (CHR_A + v - 8'd10);
  endfunction

  task automatic decode_frame_beat(cmd_t cmd, logic [7:0] b, logic [7:0] idx);
    frame_result_t r;
    logic [8:0]    pos;
    logic [7:0]    k;
    r = '0;
    case (cmd)
      CMD_BYTE: begin
        if (!sh_held) begin
          if (!sh_loading) begin
            sh_loading  = 1'b1;
            sh_count    = 9'd1;
            sh_idle     = '0;
            sh_start_ok = (b == CH_OPEN);
            sh_bad      = 1'b0;
            sh_high     = '0;
            sh_prev     = b;
          end else if (sh_count < FRAME_CHARS) begin
            if (sh_count >= 9'd2) begin
              pos = sh_count - 9'd1;
              if (!is_hex_char(sh_prev)) sh_bad = 1'b1;
              if (pos[0]) begin
                sh_high = char_nibble(sh_prev);
              end else begin
                k = pos[8:1] - 8'd1;
                shadow_store[k]  = {sh_high, char_nibble(sh_prev)};
                store_written[k] = 1'b1;
              end
            end
            sh_prev  = b;
            sh_count = sh_count + 9'd1;
            sh_idle  = '0;
          end
        end
      end
      CMD_TICK: begin
        if (sh_loading && !sh_held) begin
          if (sh_idle < sh_limit) begin
            sh_idle = sh_idle + 8'd1;
          end else begin
            sh_loading = 1'b0;
            sh_held    = 1'b1;
            r.kind     = KIND_REPORT;
            if (sh_count < MIN_CHARS) r.status = ST_SHORT;
            else if (sh_count[0]) r.status = ST_ODD;
            else if (!sh_start_ok || sh_bad || sh_prev != CH_CLOSE) r.status = ST_BAD;
            else begin
              r.status = ST_GOOD;
              r.plen   = 8'(sh_count / 2 - 1);
            end
            awaited_results.push_back(r);
          end
        end
      end
      CMD_RELEASE: begin
        sh_held     = 1'b0;
        sh_loading  = 1'b0;
        sh_count    = '0;
        sh_idle     = '0;
        sh_start_ok = 1'b0;
        sh_bad      = 1'b0;
        sh_prev     = '0;
        sh_high     = '0;
      end
      default: begin
        r.kind   = KIND_READ;
        r.status = ST_GOOD;
        r.data   = (idx < STORE_DEPTH) ? shadow_store[idx] : 8'd0;
        awaited_results.push_back(r);
      end
    endcase
  endtask

  task automatic note_mismatch(string what, int want, int got);
    if (mismatches < 40)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  task automatic check_result();
    frame_result_t want;
    if (awaited_results.size() == 0) begin
      note_mismatch("unexpected result kind", -1, out_ch.result_kind);
      return;
    end
    want = awaited_results.pop_front();
    if (out_ch.result_kind !== want.kind)
      note_mismatch("result_kind", want.kind, out_ch.result_kind);
    if (out_ch.frame_status !== want.status)
      note_mismatch("frame_status", want.status, out_ch.frame_status);
    if (out_ch.payload_length !== want.plen)
      note_mismatch("payload_length", want.plen, out_ch.payload_length);
    if (out_ch.data_byte !== want.data)
      note_mismatch("data_byte", want.data, out_ch.data_byte);
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      check_result();
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(stall_en && $urandom_range(99) < 29);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_beat(cmd_t cmd, logic [7:0] b, logic [7:0] idx);
    while (idle_en && $urandom_range(99) < 29) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.rx_byte    <= b;
    in_ch.read_index <= idx;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    decode_frame_beat(cmd, b, idx);
    beats_sent++;
  endtask

  task automatic send_char(logic [7:0] c);
    send_beat(CMD_BYTE, c, 8'($urandom_range(255)));
  endtask

  task automatic send_tick();
    send_beat(CMD_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic send_release();
    send_beat(CMD_RELEASE, 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic send_read(logic [7:0] idx);
    send_beat(CMD_READ, 8'($urandom_range(255)), idx);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // close the open frame on idle ticks
  task automatic close_frame();
    while (sh_loading && !sh_held) send_tick();
  endtask

  // never point at an entry that was never written
  function automatic logic [7:0] pick_read_index();
    logic [7:0] i;
    i = ($urandom_range(99) < 75) ? 8'($urandom_range(STORE_DEPTH - 1))
                                  : 8'($urandom_range(255));
    repeat (8) if (i < STORE_DEPTH && !store_written[i]) i = 8'($urandom_range(STORE_DEPTH - 1));
    if (i < STORE_DEPTH && !store_written[i])
      i = 8'(STORE_DEPTH + $urandom_range(255 - STORE_DEPTH));
    return i;
  endfunction

  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_tick_limit(logic [7:0] v);
    wait_quiet();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    sh_limit = v;
  endtask

  task automatic test_good_frame();
    send_read(8'd200);
    send_text("<0123456789>");
    close_frame();
    send_char(CH_OPEN);
    send_tick();
    for (int i = 0; i < 5; i++) send_read(8'(i));
    send_read(8'd255);
    send_read(8'(STORE_DEPTH));
    send_release();
    send_tick();
  endtask

  task automatic test_frame_errors();
    set_tick_limit(8'd0);
    send_text("<0123456789");
    close_frame();
    send_release();
    send_text("<0123456789A>");
    close_frame();
    send_release();
    send_text("<01G3456789>");
    close_frame();
    send_release();
    send_text("(0123456789>");
    close_frame();
    send_release();
    send_text("<0123456789A");
    close_frame();
    send_release();
    send_text("<AbCDEF:F>00");
    close_frame();
    send_read(8'd1);
    send_read(8'd2);
    send_release();
  endtask

  task automatic test_tick_limit();
    set_tick_limit(8'd10);
    send_text("<FEDCBA987654");
    repeat (6) send_tick();
    set_tick_limit(8'd3);
    send_char(CH_CLOSE);
    repeat (5) send_tick();
    send_release();
    set_tick_limit(8'd255);
    send_text("<A5A55A5AC3C3>");
    close_frame();
    send_read(8'd0);
    send_release();
  endtask

  task automatic test_oversize_frame();
    set_tick_limit(8'd2);
    send_char(CH_OPEN);
    for (int i = 0; i < FRAME_CHARS - 2; i++) send_char(hex_digit(4'($urandom_range(15))));
    send_char(CH_CLOSE);
    send_tick();
    send_tick();
    send_char(hex_digit(4'($urandom_range(15))));
    send_tick();
    send_read(8'd0);
    send_read(8'(STORE_DEPTH - 2));
    send_release();
  endtask

  task automatic test_release_abort();
    send_text("<01");
    send_read(8'd0);
    send_text("23");
    send_release();
    send_text("<ABCDEF012345>");
    send_read(8'd2);
    close_frame();
    for (int i = 0; i < 6; i++) send_read(8'(i));
    send_release();
  endtask

  task automatic test_backpressure();
    wait_quiet();
    idle_en      = 1'b0;
    hold_request = 150;
    repeat (60) send_read(pick_read_index());
    wait_quiet();
    idle_en = 1'b1;
  endtask

  task automatic run_random_frame();
    logic [7:0] chars[$];
    int         pairs;
    int         shape;
    int         r;
    if ($urandom_range(99) < 12)
      repeat ($urandom_range(1, 6))
        send_beat(cmd_t'($urandom_range(3)), 8'($urandom_range(255)), pick_read_index());
    if (sh_loading || sh_held) send_release();
    pairs = ($urandom_range(99) < 1) ? $urandom_range(40, 160) : $urandom_range(5, 20);
    chars.push_back(CH_OPEN);
    for (int i = 0; i < 2 * pairs; i++) chars.push_back(hex_digit(4'($urandom_range(15))));
    chars.push_back(CH_CLOSE);
    shape = $urandom_range(99);
    if (shape >= 70 && shape < 78)
      chars[$urandom_range(1, chars.size() - 2)] = 8'($urandom_range(255));
    else if (shape >= 78 && shape < 84) chars[0] = 8'($urandom_range(255));
    else if (shape >= 84 && shape < 89) chars[$] = 8'($urandom_range(255));
    else if (shape >= 89 && shape < 94)
      chars.insert($urandom_range(1, chars.size() - 1), hex_digit(4'($urandom_range(15))));
    else if (shape >= 94) chars = chars[0:$urandom_range(1, 10)];
    foreach (chars[i]) begin
      r = $urandom_range(99);
      if (r < 6) send_read(pick_read_index());
      else if (r < 12 && sh_idle < sh_limit) send_tick();
      else if (r < 13) send_tick();
      send_char(chars[i]);
    end
    close_frame();
    if ($urandom_range(99) < 30) send_char(8'($urandom_range(255)));
    if ($urandom_range(99) < 30) send_tick();
    repeat ($urandom_range(0, 3)) send_read(pick_read_index());
    send_release();
  endtask

  task automatic test_random_traffic();
    int start_beats;
    int phase;
    start_beats = beats_sent;
    phase       = 0;
    while (beats_sent - start_beats < RANDOM_BEATS) begin
      set_tick_limit((phase == 0) ? 8'd0 : 8'($urandom_range(1, 6)));
      idle_en  = (phase != 2);
      stall_en = (phase != 2);
      repeat (4) run_random_frame();
      phase++;
    end
    idle_en  = 1'b1;
    stall_en = 1'b1;
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.command    <= CMD_BYTE;
    in_ch.rx_byte    <= '0;
    in_ch.read_index <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.data      <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_good_frame();
    test_frame_errors();
    test_tick_limit();
    test_oversize_frame();
    test_release_abort();
    test_backpressure();
    test_random_traffic();
    wait_quiet();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
